>>> rtl/core/multi_slot_timeout_engine_unit_assert.svh
// Assertion macros for the timeout engine
`ifndef MULTI_SLOT_TIMEOUT_ENGINE_UNIT_ASSERT_SVH
`define MULTI_SLOT_TIMEOUT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSTEU_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timeout engine property failed");

// next-cycle implication, sampled on clock, off during reset
`define MSTEU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timeout engine property failed");

`endif

>>> rtl/core/msteu_pkg.sv
// Shared types and constants of the timeout engine
package msteu_pkg;

   localparam int FUNC_WIDTH   = 2;
   localparam int SLOT_WIDTH   = 3;
   localparam int DELAY_WIDTH  = 32;
   localparam int STATUS_WIDTH = 3;
   localparam int REM_WIDTH    = 31;
   localparam int MIN_WIDTH    = 20;
   localparam int MAX_WIDTH    = 31;
   localparam int ALU_WIDTH    = 33;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH = 31;
   localparam int MAX_RESULTS  = 8;
   localparam int CNT_WIDTH    = 4;

   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK   = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ALLOC  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ARM    = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CANCEL = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BUSY   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_EXPIRY = 3'd4;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_DELAY = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_DELAY = 1'd1;

   localparam logic [MIN_WIDTH-1:0] MIN_DELAY_RESET = 20'd5;
   localparam logic [MAX_WIDTH-1:0] MAX_DELAY_RESET = 31'd10000000;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [SLOT_WIDTH-1:0]   slot_out;
      logic [REM_WIDTH-1:0]    remaining;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type data;
   } push_bus_type;

   typedef struct packed {
      logic [ALU_WIDTH-1:0] a;
      logic [ALU_WIDTH-1:0] b;
      logic                 sub;
   } alu_req_type;

endpackage

>>> rtl/core/msteu_alu.sv
// Shared 33-bit add/subtract unit
module msteu_alu (
   input  msteu_pkg::alu_req_type           req,
   output logic [msteu_pkg::ALU_WIDTH-1:0]  sum
);

   logic [msteu_pkg::ALU_WIDTH-1:0] b_op;

   assign b_op = req.sub ? ~req.b : req.b;
   assign sum  = req.a + b_op + {{(msteu_pkg::ALU_WIDTH-1){1'b0}}, req.sub};

endmodule

>>> rtl/core/msteu_seq.sv
// Sequencer, slot state, ordered list and deadline memory
module msteu_seq #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [msteu_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic [msteu_pkg::SLOT_WIDTH-1:0]        req_slot,
   input  logic [msteu_pkg::DELAY_WIDTH-1:0]       req_delay,
   input  logic                                    csr_wr_en,
   input  logic [msteu_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [msteu_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  logic                                    out_free,
   output msteu_pkg::push_bus_type                 push_bus,
   output msteu_pkg::alu_req_type                  alu_req,
   input  logic [msteu_pkg::ALU_WIDTH-1:0]         alu_sum
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ALLOC    = 4'd1;
   localparam logic [3:0] S_ARM_MAX  = 4'd2;
   localparam logic [3:0] S_ARM_MIN  = 4'd3;
   localparam logic [3:0] S_ARM_DM1  = 4'd4;
   localparam logic [3:0] S_ARM_DL   = 4'd5;
   localparam logic [3:0] S_INS_RD   = 4'd6;
   localparam logic [3:0] S_INS_CMP  = 4'd7;
   localparam logic [3:0] S_CAN_RD   = 4'd8;
   localparam logic [3:0] S_CAN_SUB  = 4'd9;
   localparam logic [3:0] S_CAN_FIND = 4'd10;
   localparam logic [3:0] S_TICK_INC = 4'd11;
   localparam logic [3:0] S_TICK_RD  = 4'd12;
   localparam logic [3:0] S_TICK_CMP = 4'd13;
   localparam logic [3:0] S_EMIT     = 4'd14;

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   logic [msteu_pkg::SLOT_WIDTH-1:0]  slot_ff, slot_in;
   logic [msteu_pkg::DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic [msteu_pkg::MIN_WIDTH-1:0]   min_delay_ff, min_delay_in;
   logic [msteu_pkg::MAX_WIDTH-1:0]   max_delay_ff, max_delay_in;
   logic [31:0] now_ff, now_in;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in, alloc_ff, alloc_in;
   logic [SW-1:0] order_ff [NUM_SLOTS];
   logic [SW-1:0] order_in [NUM_SLOTS];
   logic [LW-1:0] len_ff, len_in, pos_ff, pos_in;
   logic [msteu_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic hold_v_ff, hold_v_in;
   logic [SW-1:0] hold_slot_ff, hold_slot_in;
   logic [31:0] tmp_ff, tmp_in;
   logic [msteu_pkg::REM_WIDTH-1:0] left_ff, left_in;
   msteu_pkg::result_type emit_ff, emit_in;

   logic [31:0] dl_mem [NUM_SLOTS];
   logic [31:0] rd_data_ff;
   logic [SW-1:0] rd_addr, wr_addr;
   logic [31:0] wr_data;
   logic wr_en;

   logic rm_en, ins_en;
   logic [LW-1:0] rm_pos, ins_pos;
   logic [SW-1:0] ins_slot;

   logic [SW-1:0] req_idx, slot_idx, head;
   logic req_out_of_range, due;

   assign req_idx          = SW'(req_slot);
   assign slot_idx         = SW'(slot_ff);
   assign head             = order_ff[0];
   assign req_out_of_range = (int'(req_slot) >= NUM_SLOTS);
   assign due              = (alu_sum[31:0] == 32'd0) || alu_sum[31];

   assign req_stall     = (state_ff != S_IDLE);
   assign push_bus.push = (state_ff == S_EMIT) && out_free;
   assign push_bus.data = emit_ff;

   always_comb begin
      min_delay_in = min_delay_ff;
      max_delay_in = max_delay_ff;
      if (csr_wr_en) begin
         case (csr_index)
            msteu_pkg::CSR_MIN_DELAY: min_delay_in = csr_wdata[msteu_pkg::MIN_WIDTH-1:0];
            msteu_pkg::CSR_MAX_DELAY: max_delay_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      slot_in      = slot_ff;
      delay_in     = delay_ff;
      now_in       = now_ff;
      armed_in     = armed_ff;
      alloc_in     = alloc_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      hold_v_in    = hold_v_ff;
      hold_slot_in = hold_slot_ff;
      tmp_in       = tmp_ff;
      left_in      = left_ff;
      emit_in      = emit_ff;
      alu_req      = '0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = slot_idx;
      wr_data      = alu_sum[31:0];
      rm_en        = 1'b0;
      rm_pos       = '0;
      ins_en       = 1'b0;
      ins_pos      = pos_ff;
      ins_slot     = slot_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               slot_in  = req_slot;
               delay_in = req_delay;
               pos_in   = '0;
               ret_in   = S_IDLE;
               case (req_func)
                  msteu_pkg::FUNC_TICK: state_in = S_TICK_INC;
                  msteu_pkg::FUNC_ALLOC: state_in = S_ALLOC;
                  default: begin
                     if (req_out_of_range) begin
                        emit_in = '{status: msteu_pkg::ST_RANGE, slot_out: req_slot,
                                    remaining: '0, last: 1'b1};
                        state_in = S_EMIT;
                     end else if (req_func == msteu_pkg::FUNC_ARM) begin
                        state_in = S_ARM_MAX;
                     end else if (armed_ff[req_idx]) begin
                        state_in = S_CAN_RD;
                     end else begin
                        emit_in = '{status: msteu_pkg::ST_OK, slot_out: req_slot,
                                    remaining: '0, last: 1'b1};
                        state_in = S_EMIT;
                     end
                  end
               endcase
            end
         end
         S_ALLOC: begin
            if (!alloc_ff[pos_ff[SW-1:0]]) begin
               alloc_in[pos_ff[SW-1:0]] = 1'b1;
               emit_in = '{status: msteu_pkg::ST_OK,
                           slot_out: msteu_pkg::SLOT_WIDTH'(pos_ff),
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else if (pos_ff == LW'(NUM_SLOTS - 1)) begin
               emit_in = '{status: msteu_pkg::ST_FULL, slot_out: '0,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_ARM_MAX: begin
            alu_req = '{a: {2'b00, max_delay_ff}, b: {delay_ff[31], delay_ff}, sub: 1'b1};
            if (alu_sum[msteu_pkg::ALU_WIDTH-1]) begin
               emit_in = '{status: msteu_pkg::ST_RANGE, slot_out: slot_ff,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else begin
               state_in = S_ARM_MIN;
            end
         end
         S_ARM_MIN: begin
            alu_req = '{a: {delay_ff[31], delay_ff}, b: {13'd0, min_delay_ff}, sub: 1'b1};
            if (alu_sum[msteu_pkg::ALU_WIDTH-1] || alu_sum == '0) begin
               emit_in = '{status: msteu_pkg::ST_RANGE, slot_out: slot_ff,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else if (armed_ff[slot_idx]) begin
               emit_in = '{status: msteu_pkg::ST_BUSY, slot_out: slot_ff,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else begin
               state_in = S_ARM_DM1;
            end
         end
         S_ARM_DM1: begin
            alu_req  = '{a: {delay_ff[31], delay_ff}, b: 33'd1, sub: 1'b1};
            tmp_in   = alu_sum[31:0];
            state_in = S_ARM_DL;
         end
         S_ARM_DL: begin
            alu_req = '{a: {1'b0, now_ff}, b: {1'b0, tmp_ff}, sub: 1'b0};
            tmp_in  = alu_sum[31:0];
            wr_en   = 1'b1;
            armed_in[slot_idx] = 1'b1;
            pos_in   = '0;
            state_in = S_INS_RD;
         end
         S_INS_RD: begin
            if (pos_ff < len_ff) begin
               rd_addr  = order_ff[pos_ff[SW-1:0]];
               state_in = S_INS_CMP;
            end else begin
               ins_en  = 1'b1;
               len_in  = len_ff + 1'b1;
               emit_in = '{status: msteu_pkg::ST_OK, slot_out: slot_ff,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end
         end
         S_INS_CMP: begin
            alu_req = '{a: {1'b0, tmp_ff}, b: {1'b0, rd_data_ff}, sub: 1'b1};
            if (alu_sum[31]) begin
               ins_en  = 1'b1;
               len_in  = len_ff + 1'b1;
               emit_in = '{status: msteu_pkg::ST_OK, slot_out: slot_ff,
                           remaining: '0, last: 1'b1};
               state_in = S_EMIT;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_CAN_RD: begin
            rd_addr  = slot_idx;
            state_in = S_CAN_SUB;
         end
         S_CAN_SUB: begin
            alu_req = '{a: {1'b0, rd_data_ff}, b: {1'b0, now_ff}, sub: 1'b1};
            left_in = alu_sum[31] ? '0 : alu_sum[msteu_pkg::REM_WIDTH-1:0];
            armed_in[slot_idx] = 1'b0;
            pos_in   = '0;
            state_in = S_CAN_FIND;
         end
         S_CAN_FIND: begin
            if (pos_ff < len_ff && order_ff[pos_ff[SW-1:0]] != slot_idx) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               if (pos_ff < len_ff) begin
                  rm_en  = 1'b1;
                  rm_pos = pos_ff;
                  len_in = len_ff - 1'b1;
               end
               emit_in = '{status: msteu_pkg::ST_OK, slot_out: slot_ff,
                           remaining: left_ff, last: 1'b1};
               state_in = S_EMIT;
            end
         end
         S_TICK_INC: begin
            alu_req   = '{a: {1'b0, now_ff}, b: 33'd1, sub: 1'b0};
            now_in    = alu_sum[31:0];
            cnt_in    = '0;
            hold_v_in = 1'b0;
            state_in  = S_TICK_RD;
         end
         S_TICK_RD: begin
            if (len_ff != '0 && cnt_ff < msteu_pkg::CNT_WIDTH'(msteu_pkg::MAX_RESULTS)) begin
               rd_addr  = head;
               state_in = S_TICK_CMP;
            end else if (hold_v_ff) begin
               emit_in = '{status: msteu_pkg::ST_EXPIRY,
                           slot_out: msteu_pkg::SLOT_WIDTH'(hold_slot_ff),
                           remaining: '0, last: 1'b1};
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TICK_CMP: begin
            alu_req = '{a: {1'b0, rd_data_ff}, b: {1'b0, now_ff}, sub: 1'b1};
            if (due) begin
               armed_in[head] = 1'b0;
               rm_en        = 1'b1;
               len_in       = len_ff - 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               hold_v_in    = 1'b1;
               hold_slot_in = head;
               if (hold_v_ff) begin
                  emit_in = '{status: msteu_pkg::ST_EXPIRY,
                              slot_out: msteu_pkg::SLOT_WIDTH'(hold_slot_ff),
                              remaining: '0, last: 1'b0};
                  ret_in   = S_TICK_RD;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_TICK_RD;
               end
            end else if (hold_v_ff) begin
               emit_in = '{status: msteu_pkg::ST_EXPIRY,
                           slot_out: msteu_pkg::SLOT_WIDTH'(hold_slot_ff),
                           remaining: '0, last: 1'b1};
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ordered list: shift out at rm_pos, or open a gap at ins_pos
   always_comb begin
      order_in = order_ff;
      if (rm_en) begin
         for (int i = 0; i < NUM_SLOTS - 1; i++) begin
            if (LW'(i) >= rm_pos) order_in[i] = order_ff[i+1];
         end
      end
      if (ins_en) begin
         for (int i = 1; i < NUM_SLOTS; i++) begin
            if (LW'(i) > ins_pos) order_in[i] = order_ff[i-1];
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (LW'(i) == ins_pos) order_in[i] = ins_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         min_delay_ff <= msteu_pkg::MIN_DELAY_RESET;
         max_delay_ff <= msteu_pkg::MAX_DELAY_RESET;
         now_ff       <= '0;
         armed_ff     <= '0;
         alloc_ff     <= '0;
         order_ff     <= '{default: '0};
         len_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         hold_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         min_delay_ff <= min_delay_in;
         max_delay_ff <= max_delay_in;
         now_ff       <= now_in;
         armed_ff     <= armed_in;
         alloc_ff     <= alloc_in;
         order_ff     <= order_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         hold_v_ff    <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      delay_ff     <= delay_in;
      hold_slot_ff <= hold_slot_in;
      tmp_ff       <= tmp_in;
      left_ff      <= left_in;
      emit_ff      <= emit_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) dl_mem[wr_addr] <= wr_data;
      rd_data_ff <= dl_mem[rd_addr];
   end

endmodule

>>> rtl/core/multi_slot_timeout_engine_unit.sv
// Top level of the multi-slot timeout engine: sequencer, shared adder, result register
//
//  channel | ports                                    | direction
//  req     | req_valid req_stall req_func/slot/delay   | in  (stall out)
//  rsp     | rsp_valid rsp_stall rsp_status/slot_out/  | out (stall in)
//          | rsp_remaining/rsp_last                    |
//  csr     | csr_wr_en csr_index csr_wdata             | in
//
// One item at a time through the single 33-bit adder.
// Tick: advances the time, then removes due head entries and sends an expiry for each.
// Arm: range and busy checks, then the deadline is written and the list walked to insert it.
// Cancel: reads the deadline, returns the time left, drops the entry; allocate: first free slot.
// Synchronous reset clears all slots, the list, the count and the control registers to defaults.
// A stalled result holds in the output register; the next item is taken meanwhile.
module multi_slot_timeout_engine_unit #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [msteu_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic [msteu_pkg::SLOT_WIDTH-1:0]        req_slot,
   input  logic signed [msteu_pkg::DELAY_WIDTH-1:0] req_delay,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [msteu_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [msteu_pkg::SLOT_WIDTH-1:0]        rsp_slot_out,
   output logic [msteu_pkg::REM_WIDTH-1:0]         rsp_remaining,
   output logic                                    rsp_last,
   input  logic                                    csr_wr_en,
   input  logic [msteu_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [msteu_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

`include "multi_slot_timeout_engine_unit_assert.svh"

   msteu_pkg::push_bus_type push_bus;
   msteu_pkg::alu_req_type  alu_req;
   logic [msteu_pkg::ALU_WIDTH-1:0] alu_sum;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in;
   msteu_pkg::result_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   msteu_seq #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_slot  (req_slot),
      .req_delay (req_delay),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_free  (out_free),
      .push_bus  (push_bus),
      .alu_req   (alu_req),
      .alu_sum   (alu_sum)
   );

   msteu_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push_bus.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_bus.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_data_ff.status;
   assign rsp_slot_out  = rsp_data_ff.slot_out;
   assign rsp_remaining = rsp_data_ff.remaining;
   assign rsp_last      = rsp_data_ff.last;

   `MSTEU_ASSERT_IMPLY(a_push_needs_room, push_bus.push, out_free)
   `MSTEU_ASSERT_IMPLY(a_no_push_on_accept, req_valid && !req_stall, !push_bus.push)
   `MSTEU_ASSERT_IMPLY(a_remaining_only_ok,
      rsp_valid && rsp_status != msteu_pkg::ST_OK, rsp_remaining == '0)
   `MSTEU_ASSERT_NEXT(a_push_shows, push_bus.push, rsp_valid)

endmodule
